/* sv/vcbq_pkg.sv */
// ----------------------------------------------------------------------------
// vcbq_pkg
// Types and fixed widths for the voltage-controlled biquad.
// ----------------------------------------------------------------------------
`default_nettype none

package vcbq_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LL,
    ST_DIV_AL,
    ST_RCP_SETUP,
    ST_DIV_RCP,
    ST_A1,
    ST_A2,
    ST_T1,
    ST_T2,
    ST_W0,
    ST_TAP,
    ST_GAIN,
    ST_Y,
    ST_FIN
  } state_t;

  localparam int CUT_W  = 24;
  localparam int QUAL_W = 24;
  localparam int MODE_W = 3;
  localparam int COEF_W = 32;

  localparam logic [MODE_W-1:0] MODE_LP   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BP   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RBP  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HP   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_THRU = 3'd4;

  // shared multiplier: 52-bit signed A split in two 26-bit halves, 34-bit signed B
  localparam int OPA_W    = 52;
  localparam int OPA_HALF = 26;
  localparam int OPB_W    = 34;
  localparam int PROD_W   = OPA_HALF + 1 + OPB_W;
  localparam int FULL_W   = OPA_W + OPB_W + 1;
  localparam int RES_W    = 64;
  localparam int SHIFT_W  = 6;

  localparam logic [SHIFT_W-1:0] SH_NONE    = 6'd0;
  localparam logic [SHIFT_W-1:0] SH_COEF    = 6'd33;
  localparam logic [SHIFT_W-1:0] SH_TAP     = 6'd30;
  localparam logic [SHIFT_W-1:0] SH_GAIN    = 6'd16;
  localparam logic [SHIFT_W-1:0] SH_GAIN_HP = 6'd32;

  localparam logic signed [OPA_W-1:0] ONE_Q32 = 52'sh1_0000_0000;
  localparam logic signed [OPA_W-1:0] TWO_Q32 = 52'sh2_0000_0000;

  // shared restoring divider
  localparam int DIVN_W = 36;
  localparam int DEN_W  = 50;
  localparam int DCNT_W = 6;
  localparam int FRAC_SHIFT = 12;
  localparam logic [DCNT_W-1:0] AL_STEPS  = 6'd36;
  localparam logic [DCNT_W-1:0] RCP_STEPS = 6'd32;
  localparam logic [DEN_W-1:0]  RCP_SEED  = 50'h0_0000_8000_0000;
  localparam logic [DEN_W-1:0]  ONE_D     = 50'h1_0000_0000;

endpackage

`default_nettype wire

/* sv/voltage_controlled_biquad.sv */
// ----------------------------------------------------------------------------
// voltage_controlled_biquad
// Bilinear biquad (LP/BP/resonant BP/HP/thru), coefficient control per update interval.
// ----------------------------------------------------------------------------
// LP skips the gain multiply and pass-through skips the filter. Requests are taken
// only in the idle state: a new one is taken only after the last result has left
// ST_FIN, which waits while m_tvalid is high and m_tready low. A request that
// reloads coefficients adds a multiply, a 36-step and a 32-step restoring division
// on the shared divider and a setup state. One 27x34 multiplier serves every product.
// Reset (synchronous, rst high) clears the delays and phase, mode = pass-through.
`default_nettype none

module voltage_controlled_biquad #(
  parameter int SAMPLE_BITS          = 24,
  parameter int STATE_BITS           = 32,
  parameter int COEF_UPDATE_INTERVAL = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [vcbq_pkg::MODE_W-1:0]  cfg_wr_data,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // sample_in, cutoff_warp, quality
  input  wire logic [((SAMPLE_BITS+vcbq_pkg::CUT_W+vcbq_pkg::QUAL_W+7)/8)*8-1:0] s_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // sample_out
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata
);
  import vcbq_pkg::*;

  localparam int OUT_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int PH_W   = (COEF_UPDATE_INTERVAL > 1) ? $clog2(COEF_UPDATE_INTERVAL) : 1;
  localparam int XL     = (SAMPLE_BITS <= 25) ? 25 - SAMPLE_BITS : 0;
  localparam int XR     = (SAMPLE_BITS > 25) ? SAMPLE_BITS - 25 : 0;
  localparam logic [SHIFT_W-1:0] SH_OUT = SHIFT_W'(56 - SAMPLE_BITS);
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(COEF_UPDATE_INTERVAL - 1);
  localparam logic signed [OPA_W-1:0] W_MAX = OPA_W'((64'sd1 <<< (STATE_BITS - 1)) - 1);
  localparam logic signed [OPA_W-1:0] W_MIN = -W_MAX - 1;
  localparam logic signed [RES_W-1:0] Y_MAX = RES_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RES_W-1:0] Y_MIN = -Y_MAX - 1;

  state_t state, state_next;

  logic [MODE_W-1:0] filter_mode;
  logic [PH_W-1:0]   update_phase;
  logic              accept;
  logic              thru;

  logic signed [SAMPLE_BITS-1:0] x_r, y_r;
  logic [CUT_W-1:0]  l_r, q_r, q_in;
  logic [CUT_W-1:0]  held_cutoff;
  logic [COEF_W-1:0] held_damping, held_reciprocal, gain;
  logic [2*CUT_W-1:0] held_ll;

  logic signed [STATE_BITS-1:0] delay_one, delay_two, w0;
  logic signed [OPB_W-1:0] a1, a2;
  logic signed [OPA_W-1:0] t1, t2, tap;

  // shared multiplier
  logic [1:0] mstep;
  logic       mul_on, mul_done;
  logic signed [OPA_W-1:0]    op_a;
  logic signed [OPB_W-1:0]    op_b;
  logic [SHIFT_W-1:0]         op_sh;
  logic signed [OPA_HALF:0]   mul_x;
  logic signed [PROD_W-1:0]   mul_p, mprod, macc;
  logic signed [FULL_W-1:0]   full;
  logic signed [RES_W-1:0]    mres;

  // shared divider
  logic [DEN_W-1:0]  dv_rem, dv_den, dv_rem_next;
  logic [DIVN_W-1:0] dv_num, dv_quo, dv_quo_next;
  logic [DCNT_W-1:0] dv_cnt;
  logic [DEN_W:0]    dv_trial, dv_diff;
  logic              dv_ge, dv_last;
  logic [COEF_W-1:0] al_sat;
  logic [DEN_W-1:0]  den_rcp;

  logic signed [OPA_W-1:0] ll_s, al_s, l_s, c1, c2, xs, w_sum;
  logic signed [OPA_W-1:0] w0_e, w1_e, w2_e;
  logic signed [OPB_W-1:0] rcp_b;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign thru     = (filter_mode > MODE_HP);
  assign q_in     = s_tdata[SAMPLE_BITS+CUT_W +: QUAL_W];

  assign ll_s  = $signed(OPA_W'(held_ll));
  assign al_s  = $signed(OPA_W'(held_damping));
  assign l_s   = $signed(OPA_W'(held_cutoff));
  assign rcp_b = $signed(OPB_W'(held_reciprocal));
  assign c1    = TWO_Q32 - (ll_s <<< 1);
  assign c2    = ONE_Q32 + ll_s - (al_s <<< 16);
  assign xs    = (OPA_W'(x_r) <<< XL) >>> XR;
  assign w_sum = xs - t1 - t2;
  assign w0_e  = OPA_W'(w0);
  assign w1_e  = OPA_W'(delay_one);
  assign w2_e  = OPA_W'(delay_two);

  // multiplier datapath: low half, high half, then align and shift
  assign mul_x = (mstep == 2'd0) ? $signed({1'b0, op_a[OPA_HALF-1:0]})
                                 : $signed({op_a[OPA_W-1], op_a[OPA_W-1:OPA_HALF]});
  assign mul_p    = mul_x * op_b;
  assign full     = FULL_W'(macc) + (FULL_W'(mprod) <<< OPA_HALF);
  assign mres     = RES_W'(full >>> op_sh);
  assign mul_done = mul_on && (mstep == 2'd2);

  // divider step
  assign dv_trial    = {dv_rem, dv_num[DIVN_W-1]};
  assign dv_diff     = dv_trial - {1'b0, dv_den};
  assign dv_ge       = (dv_trial >= {1'b0, dv_den});
  assign dv_rem_next = dv_ge ? dv_diff[DEN_W-1:0] : dv_trial[DEN_W-1:0];
  assign dv_quo_next = {dv_quo[DIVN_W-2:0], dv_ge};
  assign dv_last     = (dv_cnt == DCNT_W'(1));
  assign al_sat      = (|dv_quo_next[DIVN_W-1:COEF_W]) ? '1 : dv_quo_next[COEF_W-1:0];
  assign den_rcp     = DEN_W'(held_ll) + ONE_D + (DEN_W'(held_damping) << 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_on     = 1'b0;
    op_a       = '0;
    op_b       = rcp_b;
    op_sh      = SH_NONE;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (update_phase == '0) state_next = ST_LL;
          else if (thru) state_next = ST_FIN;
          else state_next = ST_A1;
        end
      end
      ST_LL: begin
        mul_on = 1'b1;
        op_a   = $signed(OPA_W'(l_r));
        op_b   = $signed(OPB_W'(l_r));
        if (mstep == 2'd2) state_next = ST_DIV_AL;
      end
      ST_DIV_AL: begin
        if (dv_last) state_next = ST_RCP_SETUP;
      end
      ST_RCP_SETUP: state_next = ST_DIV_RCP;
      ST_DIV_RCP: begin
        if (dv_last) state_next = thru ? ST_FIN : ST_A1;
      end
      ST_A1: begin
        mul_on = 1'b1;
        op_a   = c1;
        op_sh  = SH_COEF;
        if (mstep == 2'd2) state_next = ST_A2;
      end
      ST_A2: begin
        mul_on = 1'b1;
        op_a   = c2;
        op_sh  = SH_COEF;
        if (mstep == 2'd2) state_next = ST_T1;
      end
      ST_T1: begin
        mul_on = 1'b1;
        op_a   = w1_e;
        op_b   = a1;
        op_sh  = SH_TAP;
        if (mstep == 2'd2) state_next = ST_T2;
      end
      ST_T2: begin
        mul_on = 1'b1;
        op_a   = w2_e;
        op_b   = a2;
        op_sh  = SH_TAP;
        if (mstep == 2'd2) state_next = ST_W0;
      end
      ST_W0: state_next = ST_TAP;
      ST_TAP: state_next = (filter_mode == MODE_LP) ? ST_Y : ST_GAIN;
      ST_GAIN: begin
        mul_on = 1'b1;
        case (filter_mode)
          MODE_BP: begin
            op_a  = al_s;
            op_sh = SH_GAIN;
          end
          MODE_RBP: begin
            op_a  = l_s;
            op_sh = SH_GAIN;
          end
          default: begin
            op_a  = ll_s;
            op_sh = SH_GAIN_HP;
          end
        endcase
        if (mstep == 2'd2) state_next = ST_Y;
      end
      ST_Y: begin
        mul_on = 1'b1;
        op_a   = tap;
        op_b   = $signed(OPB_W'(gain));
        op_sh  = SH_OUT;
        if (mstep == 2'd2) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= MODE_THRU;
      update_phase <= '0;
      mstep        <= 2'd0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_wr_en) filter_mode <= cfg_wr_data;
      if (accept) update_phase <= (update_phase == PH_LAST) ? '0 : update_phase + 1'b1;
      if (mul_on) mstep <= (mstep == 2'd2) ? 2'd0 : mstep + 2'd1;
      if (state == ST_FIN && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // delays
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
    end else if (state == ST_Y && mul_done) begin
      delay_two <= delay_one;
      delay_one <= w0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= $signed(s_tdata[SAMPLE_BITS-1:0]);
      l_r <= s_tdata[SAMPLE_BITS +: CUT_W];
      q_r <= (q_in == '0) ? CUT_W'(1) : q_in;
      if (update_phase == '0) held_cutoff <= s_tdata[SAMPLE_BITS +: CUT_W];
    end

    if (mul_on) begin
      mprod <= mul_p;
      if (mstep == 2'd1) macc <= mprod;
    end

    case (state)
      ST_LL: begin
        if (mul_done) begin
          held_ll <= mres[2*CUT_W-1:0];
          dv_rem  <= '0;
          dv_num  <= {l_r, FRAC_SHIFT'(0)};
          dv_den  <= DEN_W'(q_r);
          dv_quo  <= '0;
          dv_cnt  <= AL_STEPS;
        end
      end
      ST_DIV_AL, ST_DIV_RCP: begin
        dv_rem <= dv_rem_next;
        dv_num <= dv_num << 1;
        dv_quo <= dv_quo_next;
        dv_cnt <= dv_cnt - 1'b1;
        if (dv_last) begin
          if (state == ST_DIV_AL) held_damping <= al_sat;
          else held_reciprocal <= dv_quo_next[COEF_W-1:0];
        end
      end
      ST_RCP_SETUP: begin
        // 2^63 / D: D >= 2^32, so seed the remainder with 2^31 and run 32 steps
        dv_den <= den_rcp;
        dv_rem <= RCP_SEED;
        dv_num <= '0;
        dv_quo <= '0;
        dv_cnt <= RCP_STEPS;
      end
      ST_A1: if (mul_done) a1 <= mres[OPB_W-1:0];
      ST_A2: if (mul_done) a2 <= mres[OPB_W-1:0];
      ST_T1: if (mul_done) t1 <= mres[OPA_W-1:0];
      ST_T2: if (mul_done) t2 <= mres[OPA_W-1:0];
      ST_W0: begin
        if (w_sum > W_MAX) w0 <= W_MAX[STATE_BITS-1:0];
        else if (w_sum < W_MIN) w0 <= W_MIN[STATE_BITS-1:0];
        else w0 <= w_sum[STATE_BITS-1:0];
      end
      ST_TAP: begin
        gain <= held_reciprocal;
        case (filter_mode)
          MODE_LP: tap <= w0_e + (w1_e <<< 1) + w2_e;
          MODE_HP: tap <= w0_e - (w1_e <<< 1) + w2_e;
          default: tap <= w0_e - w2_e;
        endcase
      end
      ST_GAIN: if (mul_done) gain <= mres[COEF_W-1:0];
      ST_Y: begin
        if (mul_done) begin
          if (mres > Y_MAX) y_r <= Y_MAX[SAMPLE_BITS-1:0];
          else if (mres < Y_MIN) y_r <= Y_MIN[SAMPLE_BITS-1:0];
          else y_r <= mres[SAMPLE_BITS-1:0];
        end
      end
      ST_FIN: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= OUT_W'($unsigned(thru ? x_r : y_r));
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* dv/voltage_controlled_biquad_tb.sv */
// ----------------------------------------------------------------------------
// voltage_controlled_biquad_tb
// Self-checking bench for the voltage-controlled biquad. Drives sample requests
// with per-sample cutoff and Q across all filter modes, with random idle cycles
// on both streams. Every result is checked against a bit-exact fixed-point model.
// ----------------------------------------------------------------------------
`default_nettype none

module voltage_controlled_biquad_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vcbq_pkg::*;

  localparam int SB = 24;
  localparam int IN_W = 72;
  localparam int OUT_W = 24;
  localparam int N_RAND = 1700;
  localparam longint CYCLE_LIMIT = 64'd1_500_000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [MODE_W-1:0] cfg_wr_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;    // sample_in, cutoff_warp, quality
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;        // sample_out

  voltage_controlled_biquad dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // filter model state
  logic signed [31:0] w_one, w_two;
  logic [31:0] rcp_hold, damp_hold;
  logic [23:0] cut_hold;
  int unsigned phase;
  logic [MODE_W-1:0] mode_reg;

  logic [OUT_W-1:0] expected_samples[$];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 1'b0;      // no idling in this stretch

  function automatic logic signed [127:0] floor_shr(logic signed [127:0] v, int s);
    return v >>> s;      // arithmetic shift is floor
  endfunction

  // floor(a*b/2^s) with a clamp to the signed 63-bit range
  function automatic logic signed [127:0] mulsh(logic signed [127:0] a,
                                               logic signed [127:0] b, int s);
    logic signed [127:0] p, lim, r;
    p = a * b;
    lim = 128'sh3FFF_FFFF_FFFF_FFFF;
    r = floor_shr(p, s);
    if (r > lim) r = lim;
    if (r < -lim - 1) r = -lim - 1;
    return r;
  endfunction

  function automatic logic signed [127:0] sat(logic signed [127:0] v, int bits);
    logic signed [127:0] top;
    top = (128'sd1 <<< (bits - 1)) - 1;
    return v > top ? top : (v < -top - 1 ? -top - 1 : v);
  endfunction

  function automatic logic [OUT_W-1:0] filter_sample(logic [IN_W-1:0] req);
    logic signed [127:0] x, ll, c1, c2, a1, a2, w0, y, g, l, q, al, d, r;
    if (phase == 0) begin
      l = req[47:24];
      q = req[71:48];
      if (q == 0) q = 1;
      al = (l <<< 12) / q;
      if (al > 128'shFFFF_FFFF) al = 128'shFFFF_FFFF;
      d = l * l + (128'sd1 <<< 32) + (al <<< 16);
      cut_hold = l[23:0];
      damp_hold = al[31:0];
      r = (128'sd1 <<< 63) / d;
      rcp_hold = r[31:0];
    end
    phase = (phase + 1 >= 4) ? 0 : phase + 1;
    if (mode_reg > MODE_HP) return req[23:0];
    x = $signed(req[23:0]) * 2;
    ll = $signed({1'b0, cut_hold}) * $signed({1'b0, cut_hold});
    c1 = (128'sd2 <<< 32) - 2 * ll;
    c2 = (128'sd1 <<< 32) + ll - ($signed({1'b0, damp_hold}) <<< 16);
    a1 = mulsh(c1, $signed({1'b0, rcp_hold}), 33);
    a2 = mulsh(c2, $signed({1'b0, rcp_hold}), 33);
    w0 = x - mulsh(a1, w_one, 30) - mulsh(a2, w_two, 30);
    w0 = sat(w0, 32);
    case (mode_reg)
      MODE_LP: y = mulsh(w0 + 2 * w_one + w_two, $signed({1'b0, rcp_hold}), 56 - SB);
      MODE_BP: begin
        g = mulsh($signed({1'b0, rcp_hold}), $signed({1'b0, damp_hold}), 16);
        y = mulsh(w0 - w_two, g, 56 - SB);
      end
      MODE_RBP: begin
        g = mulsh($signed({1'b0, rcp_hold}), $signed({1'b0, cut_hold}), 16);
        y = mulsh(w0 - w_two, g, 56 - SB);
      end
      default: begin
        g = mulsh($signed({1'b0, rcp_hold}), ll, 32);
        y = mulsh(w0 - 2 * w_one + w_two, g, 56 - SB);
      end
    endcase
    w_two = w_one;
    w_one = w0[31:0];
    y = sat(y, SB);
    return y[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    $display("mismatch %s: sample_out got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // result side: random stall, check in order
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0)
          report_mismatch("unexpected result", m_tdata, 'x);
        else if (m_tdata !== expected_samples[0])
          report_mismatch("sample_out", m_tdata, expected_samples.pop_front());
        else
          void'(expected_samples.pop_front());
      end
      m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL voltage_controlled_biquad");
      $finish;
    end
  end

  // one request; check_val applies when has_check is set (typed-in expectation)
  // tvalid stays high after acceptance until the next request or an idle cycle
  task automatic send_request(logic [IN_W-1:0] req, bit has_check, logic [OUT_W-1:0] check_val);
    logic [OUT_W-1:0] p;
    while (!quiet && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= req;
    s_tvalid <= 1'b1;
    // look at tready mid-cycle so the accepting edge is known before it comes
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    p = filter_sample(req);
    if (has_check && p !== check_val) report_mismatch("directed row model", p, check_val);
    expected_samples.push_back(has_check ? check_val : p);
  endtask

  task automatic set_mode(logic [MODE_W-1:0] m);
    s_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    cfg_wr_data <= m;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_reg = m;
  endtask

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic signed [23:0] smp;
    logic [23:0] cut;
    logic [23:0] qual;
    bit has_check;
    logic [OUT_W-1:0] check_val;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    // pass-through after reset: output equals input
    '{MODE_THRU, 24'sh7FFFFF, 24'hFFFFFF, 24'h000000, 1'b1, 24'h7FFFFF},
    '{MODE_THRU, 24'sh800000, 24'h000000, 24'hFFFFFF, 1'b1, 24'h800000},
    '{MODE_THRU, 24'sh000001, 24'h010000, 24'h001000, 1'b1, 24'h000001},
    '{MODE_THRU, 24'shFFFFFF, 24'h008000, 24'h000B50, 1'b1, 24'hFFFFFF},
    '{MODE_LP,  24'sh7FFFFF, 24'h00C000, 24'h000B50, 1'b0, '0},
    '{MODE_LP,  24'sh800000, 24'h00C000, 24'h000B50, 1'b0, '0},
    '{MODE_LP,  24'sh400000, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
    '{MODE_LP,  24'sh000000, 24'h000000, 24'h000000, 1'b0, '0},
    '{MODE_BP,  24'sh7FFFFF, 24'h002000, 24'h000001, 1'b0, '0},
    '{MODE_BP,  24'sh800000, 24'h002000, 24'h000000, 1'b0, '0},
    '{MODE_BP,  24'sh123456, 24'h010000, 24'h010000, 1'b0, '0},
    '{MODE_BP,  24'sh7FFFFF, 24'hFFFFFF, 24'h000000, 1'b0, '0},
    '{MODE_RBP, 24'sh7FFFFF, 24'h018000, 24'h004000, 1'b0, '0},
    '{MODE_RBP, 24'sh800000, 24'h018000, 24'h004000, 1'b0, '0},
    '{MODE_RBP, 24'sh000001, 24'hFFFFFF, 24'h000001, 1'b0, '0},
    '{MODE_RBP, 24'shABCDEF, 24'h000001, 24'hFFFFFF, 1'b0, '0},
    '{MODE_HP,  24'sh7FFFFF, 24'h040000, 24'h000B50, 1'b0, '0},
    '{MODE_HP,  24'sh800000, 24'h040000, 24'h000B50, 1'b0, '0},
    '{MODE_HP,  24'sh7FFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
    '{MODE_HP,  24'sh800000, 24'h000000, 24'h000000, 1'b0, '0},
    // unused mode acts as pass-through
    '{MODE_UNUSED, 24'sh5A5A5A, 24'h123456, 24'h654321, 1'b1, 24'h5A5A5A},
    '{MODE_UNUSED, 24'sh800000, 24'h000000, 24'h000000, 1'b1, 24'h800000}
  };

  function automatic logic [23:0] rand_cut();
    case ($urandom_range(3))
      0: return 24'($urandom_range(24'h0FFFF));     // low cutoff
      1: return 24'($urandom_range(24'h3FFFF));
      2: return 24'($urandom_range(24'hFFFFFF));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_qual();
    case ($urandom_range(3))
      0: return 24'($urandom_range(24'h1000, 24'h8000)); // musical Q range
      1: return 24'($urandom_range(24'h0FFF));
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [MODE_W-1:0] m;
    logic [23:0] smp;
    w_one = '0; w_two = '0; rcp_hold = '0; damp_hold = '0; cut_hold = '0;
    phase = 0;
    mode_reg = MODE_THRU;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != mode_reg) set_mode(dir_rows[i].mode);
      send_request({dir_rows[i].qual, dir_rows[i].cut, dir_rows[i].smp},
                   dir_rows[i].has_check, dir_rows[i].check_val);
    end

    for (int i = 0; i < N_RAND; i++) begin
      if (i % 150 == 0) begin
        m = (i == 0) ? MODE_LP : MODE_W'($urandom_range(7));
        set_mode(m);
      end
      quiet = (i >= 600 && i < 800);
      case ($urandom_range(4))
        0: smp = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
        1: smp = 24'($urandom_range(24'h1FFF)) - 24'h1000;
        default: smp = 24'($urandom);
      endcase
      send_request({rand_qual(), rand_cut(), smp}, 1'b0, '0);
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;

    while (expected_samples.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (errors == 0)
      $display("PASS voltage_controlled_biquad");
    else
      $display("FAIL voltage_controlled_biquad");
    $finish;
  end
endmodule

`default_nettype wire
